// File: rtl/core/wse_pkg.sv
// Shared constants, types and state encodings of the windowed slope estimator.
package wse_pkg;

   localparam int HALF_WINDOW = 5;

   localparam int X_W        = 16;
   localparam int Y_W        = 24;
   localparam int SLOPE_W    = 32;
   localparam int FRAC_SHIFT = 8;

   localparam int HIST_DEPTH = 2 * HALF_WINDOW + 1;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int HIST_W     = X_W + Y_W;
   localparam int COUNT_W    = $clog2(HIST_DEPTH + 1);
   localparam int D_W        = $clog2(HALF_WINDOW + 1);

   localparam int SUM_GROW   = $clog2(HALF_WINDOW + 1);
   localparam int NUM_W      = Y_W + 1 + SUM_GROW;
   localparam int DEN_W      = X_W + 1 + SUM_GROW;
   localparam int DIVIDEND_W = NUM_W + FRAC_SHIFT;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
   localparam logic [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};

   typedef enum logic [1:0] {
      F_IDLE,
      F_SELECT,
      F_SUM,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_WINDOW,
      PH_END,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_DIVIDE,
      B_DONE
   } back_state_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] num;
      logic signed [DEN_W-1:0] den;
      logic                    last;
   } job_type;

   typedef struct packed {
      logic [SLOPE_W-1:0] slope;
      logic               divide_error;
      logic               last_result;
   } result_type;

endpackage

// File: rtl/core/wse_ram.sv
// Generic RAM with one write port and two registered read ports.
module wse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: rtl/core/wse_front.sv
// Front end: takes points, keeps the point history and forms the difference sums.
module wse_front import wse_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   output logic           full,
   input  logic [X_W-1:0] x_value,
   input  logic [Y_W-1:0] y_value,
   input  logic           last_sample,
   output logic           job_push,
   input  logic           job_full,
   output job_type        job
);

   front_state_type state_ff, state_in;
   phase_type       phase_ff, phase_in;

   logic [COUNT_W-1:0] seen_ff, seen_in;
   logic [COUNT_W-1:0] j_ff, j_in;
   logic               last_ff, last_in;
   logic [D_W-1:0]     d_ff, d_in;
   logic [HIST_AW-1:0] wptr_ff, wptr_in;
   logic [HIST_AW-1:0] a_ff, a_in;
   logic [HIST_AW-1:0] b_ff, b_in;
   logic [D_W-1:0]     k_ff, k_in;
   logic [D_W-1:0]     cnt_ff, cnt_in;
   logic               rd_valid_ff, rd_valid_in;
   logic               job_last_ff, job_last_in;
   logic signed [NUM_W-1:0] num_ff, num_in;
   logic signed [DEN_W-1:0] den_ff, den_in;

   logic               plan_job;
   logic [HIST_AW-1:0] plan_a;
   logic [HIST_AW-1:0] plan_b;
   logic [D_W-1:0]     plan_k;
   logic               plan_last;
   phase_type          phase_next;
   logic [D_W-1:0]     d_next;
   logic [COUNT_W-1:0] j_minus_d;
   logic [D_W-1:0]     k_window;

   logic               wr_en;
   logic [HIST_AW-1:0] rd_addr_a;
   logic [HIST_AW-1:0] rd_addr_b;
   logic [HIST_W-1:0]  rd_data_a;
   logic [HIST_W-1:0]  rd_data_b;
   logic signed [Y_W-1:0] ya;
   logic signed [Y_W-1:0] yb;
   logic signed [X_W-1:0] xa;
   logic signed [X_W-1:0] xb;

   // Position of the point that lies a given number of points back from the newest.
   function automatic logic [HIST_AW-1:0] hist_addr(input logic [HIST_AW-1:0] newest,
                                                   input logic [HIST_AW-1:0] back_n);
      logic [HIST_AW:0] t;
      t = {1'b0, newest} + (HIST_AW+1)'(HIST_DEPTH) - {1'b0, back_n};
      if (t >= (HIST_AW+1)'(HIST_DEPTH)) begin
         t = t - (HIST_AW+1)'(HIST_DEPTH);
      end
      return t[HIST_AW-1:0];
   endfunction

   wse_ram #(
      .WIDTH (HIST_W),
      .DEPTH (HIST_DEPTH)
   ) u_history (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wptr_in),
      .wr_data   ({x_value, y_value}),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   assign ya = rd_data_a[Y_W-1:0];
   assign yb = rd_data_b[Y_W-1:0];
   assign xa = rd_data_a[HIST_W-1:Y_W];
   assign xb = rd_data_b[HIST_W-1:Y_W];

   assign j_minus_d = j_ff - COUNT_W'(d_ff);
   assign k_window  = (j_minus_d < COUNT_W'(d_ff)) ? D_W'(j_minus_d) : d_ff;

   always_comb begin
      plan_job   = 1'b0;
      plan_a     = HIST_AW'(d_ff) + HIST_AW'(1);
      plan_b     = HIST_AW'(d_ff) - HIST_AW'(1);
      plan_k     = k_window;
      plan_last  = 1'b0;
      phase_next = phase_ff;
      d_next     = d_ff;
      case (phase_ff)
         PH_FIRST: begin
            plan_job   = (j_ff == COUNT_W'(1));
            plan_a     = HIST_AW'(1);
            plan_b     = '0;
            plan_k     = D_W'(1);
            phase_next = PH_WINDOW;
         end
         PH_WINDOW: begin
            if (last_ff) begin
               if (d_ff != '0) begin
                  plan_job = 1'b1;
                  d_next   = d_ff - D_W'(1);
               end else begin
                  phase_next = PH_END;
               end
            end else begin
               plan_job   = (d_ff != '0) &&
                            ((j_ff == COUNT_W'(HIST_DEPTH)) || !j_ff[0]);
               phase_next = PH_END;
            end
         end
         PH_END: begin
            plan_job   = last_ff;
            plan_a     = '0;
            plan_b     = HIST_AW'(1);
            plan_k     = (j_ff == '0) ? '0 : D_W'(1);
            plan_last  = 1'b1;
            phase_next = PH_DONE;
         end
         default: begin
            phase_next = PH_DONE;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (push) begin
               state_in = F_SELECT;
            end
         end
         F_SELECT: begin
            if (phase_ff == PH_DONE) begin
               state_in = F_IDLE;
            end else if (plan_job) begin
               state_in = F_SUM;
            end
         end
         F_SUM: begin
            if ((cnt_ff == k_ff) && !rd_valid_ff) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!job_full) begin
               state_in = F_SELECT;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_comb begin
      full        = (state_ff != F_IDLE);
      wr_en       = 1'b0;
      job_push    = 1'b0;
      phase_in    = phase_ff;
      seen_in     = seen_ff;
      j_in        = j_ff;
      last_in     = last_ff;
      d_in        = d_ff;
      wptr_in     = wptr_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      k_in        = k_ff;
      cnt_in      = cnt_ff;
      job_last_in = job_last_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      rd_valid_in = (state_ff == F_SUM) && (cnt_ff != k_ff);
      rd_addr_a   = hist_addr(wptr_ff, a_ff + HIST_AW'(cnt_ff));
      rd_addr_b   = hist_addr(wptr_ff, b_ff - HIST_AW'(cnt_ff));

      if (rd_valid_ff) begin
         num_in = num_ff + NUM_W'(ya) - NUM_W'(yb);
         den_in = den_ff + DEN_W'(xa) - DEN_W'(xb);
      end

      case (state_ff)
         F_IDLE: begin
            if (push) begin
               wr_en    = 1'b1;
               wptr_in  = (wptr_ff == HIST_AW'(HIST_DEPTH - 1)) ? '0
                                                                  : wptr_ff + HIST_AW'(1);
               j_in     = seen_ff;
               last_in  = last_sample;
               phase_in = PH_FIRST;
               d_in     = (seen_ff > COUNT_W'(2 * HALF_WINDOW)) ? D_W'(HALF_WINDOW)
                                                                 : D_W'(seen_ff >> 1);
               if (last_sample) begin
                  seen_in = '0;
               end else if (seen_ff != COUNT_W'(HIST_DEPTH)) begin
                  seen_in = seen_ff + COUNT_W'(1);
               end
            end
         end
         F_SELECT: begin
            if (phase_ff != PH_DONE) begin
               phase_in = phase_next;
               d_in     = d_next;
               if (plan_job) begin
                  a_in        = plan_a;
                  b_in        = plan_b;
                  k_in        = plan_k;
                  job_last_in = plan_last;
                  cnt_in      = '0;
                  num_in      = '0;
                  den_in      = '0;
               end
            end
         end
         F_SUM: begin
            if (cnt_ff != k_ff) begin
               cnt_in = cnt_ff + D_W'(1);
            end
         end
         F_PUSH: begin
            job_push = !job_full;
         end
         default: begin
         end
      endcase
   end

   assign job.num  = num_ff;
   assign job.den  = den_ff;
   assign job.last = job_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         phase_ff    <= PH_DONE;
         seen_ff     <= '0;
         wptr_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         seen_ff     <= seen_in;
         wptr_ff     <= wptr_in;
         rd_valid_ff <= rd_valid_in;
      end
      j_ff        <= j_in;
      last_ff     <= last_in;
      d_ff        <= d_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      k_ff        <= k_in;
      cnt_ff      <= cnt_in;
      job_last_ff <= job_last_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
   end

endmodule

// File: rtl/core/wse_queue.sv
// Short queue of difference sums between the front end and the divider.
module wse_queue import wse_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  job_type wdata,
   input  logic    pop,
   output logic    empty,
   output job_type rdata
);

   job_type              entries_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (count_ff == Q_CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: rtl/core/wse_back.sv
// Back end: bit-serial divider, saturation and the result output register.
module wse_back import wse_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       job_empty,
   output logic       job_pop,
   input  job_type    job,
   input  logic       pop,
   output logic       empty,
   output result_type result
);

   back_state_type state_ff, state_in;

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0]      rem_ff, rem_in;
   logic [DEN_W-1:0]      dmag_ff, dmag_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  num_neg_ff, num_neg_in;
   logic                  num_zero_ff, num_zero_in;
   logic                  den_neg_ff, den_neg_in;
   logic                  den_zero_ff, den_zero_in;
   logic                  last_ff, last_in;
   result_type            out_ff, out_in;
   logic                  out_valid_ff, out_valid_in;

   logic [NUM_W-1:0]   nmag;
   logic [DEN_W-1:0]   dmag;
   logic [DEN_W:0]     rem_sh;
   logic               fits;
   logic               q_hi_zero;
   logic               pos_over;
   logic               neg_over;
   logic [SLOPE_W-1:0] q_low;
   logic [SLOPE_W-1:0] slope_final;
   logic               out_free;

   assign nmag = job.num[NUM_W-1] ? NUM_W'(-job.num) : NUM_W'(job.num);
   assign dmag = job.den[DEN_W-1] ? DEN_W'(-job.den) : DEN_W'(job.den);

   assign rem_sh = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits   = (rem_sh >= {1'b0, dmag_ff});

   assign q_low     = quo_ff[SLOPE_W-1:0];
   assign q_hi_zero = (quo_ff[DIVIDEND_W-1:SLOPE_W] == '0);
   assign pos_over  = !q_hi_zero || q_low[SLOPE_W-1];
   assign neg_over  = !q_hi_zero || (q_low[SLOPE_W-1] && (q_low[SLOPE_W-2:0] != '0));
   assign out_free  = !out_valid_ff || pop;

   always_comb begin
      if (den_zero_ff) begin
         slope_final = num_zero_ff ? '0 : (num_neg_ff ? SLOPE_MIN : SLOPE_MAX);
      end else if (num_neg_ff ^ den_neg_ff) begin
         slope_final = neg_over ? SLOPE_MIN : (~q_low + SLOPE_W'(1));
      end else begin
         slope_final = pos_over ? SLOPE_MAX : q_low;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               state_in = B_DIVIDE;
            end
         end
         B_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      job_pop      = 1'b0;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dmag_in      = dmag_ff;
      cnt_in       = cnt_ff;
      num_neg_in   = num_neg_ff;
      num_zero_in  = num_zero_ff;
      den_neg_in   = den_neg_ff;
      den_zero_in  = den_zero_ff;
      last_in      = last_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !pop;
      case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               job_pop     = 1'b1;
               quo_in      = {nmag, {FRAC_SHIFT{1'b0}}};
               rem_in      = '0;
               dmag_in     = dmag;
               cnt_in      = DIV_CNT_W'(DIVIDEND_W - 1);
               num_neg_in  = job.num[NUM_W-1];
               num_zero_in = (job.num == '0);
               den_neg_in  = job.den[DEN_W-1];
               den_zero_in = (job.den == '0);
               last_in     = job.last;
            end
         end
         B_DIVIDE: begin
            rem_in = fits ? DEN_W'(rem_sh - {1'b0, dmag_ff}) : rem_sh[DEN_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - DIV_CNT_W'(1);
            end
         end
         B_DONE: begin
            if (out_free) begin
               out_in.slope        = slope_final;
               out_in.divide_error = den_zero_ff;
               out_in.last_result  = last_ff;
               out_valid_in        = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign empty  = !out_valid_ff;
   assign result = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dmag_ff     <= dmag_in;
      cnt_ff      <= cnt_in;
      num_neg_ff  <= num_neg_in;
      num_zero_ff <= num_zero_in;
      den_neg_ff  <= den_neg_in;
      den_zero_ff <= den_zero_in;
      last_ff     <= last_in;
      out_ff      <= out_in;
   end

endmodule

// File: rtl/core/windowed_slope_estimator.sv
// Top level of the windowed slope estimator.
// The block takes (x, y) points and returns one slope word per point, in point order,
// as (sum of y differences * 256) / (sum of x differences) over a symmetric window of
// up to five point pairs, saturated to 32 bits with 8 fraction bits; a zero x sum
// raises divide_error. A point returns zero or one slope while the scan runs, and the
// point marked last_sample flushes the remaining slopes, up to six words. In the divider
// each slope word goes through a load of the job, a bit-serial step for each of the 36
// dividend bits and a hand-over to the output register once that register is free. The
// front end forms each pair of sums through the select, sum and push states, and holds
// full until every slope of the point has been queued. A two-word queue between the
// front end and the divider, and the output register, let the next point be taken while
// earlier slopes are still being divided or wait to be popped.
module windowed_slope_estimator import wse_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [X_W-1:0]     req_x_value,
   input  logic [Y_W-1:0]     req_y_value,
   input  logic               req_last_sample,
   output logic               empty,
   input  logic               pop,
   output logic [SLOPE_W-1:0] rsp_slope,
   output logic               rsp_divide_error,
   output logic               rsp_last_result
);

   job_type    fq_job;
   job_type    qb_job;
   logic       fq_push;
   logic       fq_full;
   logic       qb_pop;
   logic       qb_empty;
   result_type result;

   wse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .x_value     (req_x_value),
      .y_value     (req_y_value),
      .last_sample (req_last_sample),
      .job_push    (fq_push),
      .job_full    (fq_full),
      .job         (fq_job)
   );

   wse_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (fq_push),
      .full  (fq_full),
      .wdata (fq_job),
      .pop   (qb_pop),
      .empty (qb_empty),
      .rdata (qb_job)
   );

   wse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (qb_empty),
      .job_pop   (qb_pop),
      .job       (qb_job),
      .pop       (pop),
      .empty     (empty),
      .result    (result)
   );

   assign rsp_slope        = result.slope;
   assign rsp_divide_error = result.divide_error;
   assign rsp_last_result  = result.last_result;

endmodule

// File: rtl/core/wse_checker.sv
// Port-level assertions for the windowed slope estimator, bound to the top level.
module wse_checker import wse_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               push,
   input logic               full,
   input logic               empty,
   input logic               pop,
   input logic [SLOPE_W-1:0] rsp_slope,
   input logic               rsp_divide_error,
   input logic               rsp_last_result
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("block not empty and ready after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> full)
      else $error("full not raised after a point was taken");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_slope) && $stable(rsp_last_result)
                            && $stable(rsp_divide_error)))
      else $error("waiting result word changed before pop");

   a_error_saturates: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_divide_error) |->
         (rsp_slope == SLOPE_MAX || rsp_slope == SLOPE_MIN || rsp_slope == '0))
      else $error("divide error word without a saturated or zero slope");

endmodule

bind windowed_slope_estimator wse_checker u_wse_checker (.*);
